FILE: src/slbm_pkg.sv
// Shared types and codes for the serial-loaded bank mapper.
package slbm_pkg;

  // Bus access kinds
  localparam logic [1:0] ACT_CPU_RD = 2'd0;
  localparam logic [1:0] ACT_CPU_WR = 2'd1;
  localparam logic [1:0] ACT_PPU_RD = 2'd2;
  localparam logic [1:0] ACT_PPU_WR = 2'd3;

  // Result targets
  localparam logic [2:0] TGT_NONE = 3'd0;
  localparam logic [2:0] TGT_PRG  = 3'd1;
  localparam logic [2:0] TGT_SRAM = 3'd2;
  localparam logic [2:0] TGT_CHR  = 3'd3;
  localparam logic [2:0] TGT_NT   = 3'd4;
  localparam logic [2:0] TGT_REG  = 3'd5;

  // Internal registers loaded by the serial port, picked by address bits 14:13
  localparam logic [1:0] SEL_CONTROL = 2'd0;
  localparam logic [1:0] SEL_CHR0    = 2'd1;
  localparam logic [1:0] SEL_CHR1    = 2'd2;
  localparam logic [1:0] SEL_PRG     = 2'd3;

  // Program banking modes
  localparam logic [1:0] PRG_MODE_FIX_LAST = 2'd3;
  localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;

  // Configuration register indexes
  localparam logic REG_PRG_COUNT = 1'b0;
  localparam logic REG_CHR_COUNT = 1'b1;

  localparam int unsigned COUNT_W = 6;
  localparam int unsigned BANK_W = 5;
  localparam int unsigned MAP_W = 19;
  localparam int unsigned SERIAL_BITS = 5;

  localparam logic [COUNT_W-1:0] PRG_COUNT_RST = 6'd2;
  localparam logic [COUNT_W-1:0] CHR_COUNT_RST = 6'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] address;
    logic [7:0]  write_data;
  } item_t;

  typedef struct packed {
    logic [1:0]        arrangement;
    logic [1:0]        program_mode;
    logic              chr_split;
    logic [BANK_W-1:0] chr_bank_first;
    logic [BANK_W-1:0] chr_bank_second;
    logic [BANK_W-1:0] program_bank;
  } map_state_t;

  typedef struct packed {
    logic [COUNT_W-1:0] prg_bank_count;
    logic [COUNT_W-1:0] chr_bank_count;
  } bank_counts_t;

  typedef struct packed {
    logic [2:0]       target;
    logic [MAP_W-1:0] mapped_address;
    logic             bank_out_of_range;
    logic [1:0]       mirroring;
    logic             chr_split_mode;
  } result_t;

endpackage

FILE: src/slbm_if.sv
// Valid/ready channel interfaces for bus accesses and translation results.
interface slbm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] address;
  logic [7:0]  write_data;

  modport source (output valid, action, address, write_data, input ready);
  modport sink (input valid, action, address, write_data, output ready);
endinterface

interface slbm_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  target;
  logic [18:0] mapped_address;
  logic        bank_out_of_range;
  logic [1:0]  mirroring;
  logic        chr_split_mode;

  modport source (output valid, target, mapped_address, bank_out_of_range, mirroring,
                  chr_split_mode, input ready);
  modport sink (input valid, target, mapped_address, bank_out_of_range, mirroring,
                chr_split_mode, output ready);
endinterface

FILE: src/slbm_cfg.sv
// APB-style configuration registers holding the bank counts.
module slbm_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output slbm_pkg::bank_counts_t counts
);

  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      counts.prg_bank_count <= slbm_pkg::PRG_COUNT_RST;
      counts.chr_bank_count <= slbm_pkg::CHR_COUNT_RST;
    end else if (wr_en) begin
      if (reg_idx == slbm_pkg::REG_PRG_COUNT) begin
        counts.prg_bank_count <= pwdata[slbm_pkg::COUNT_W-1:0];
      end else begin
        counts.chr_bank_count <= pwdata[slbm_pkg::COUNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (reg_idx == slbm_pkg::REG_PRG_COUNT) begin
      prdata = {{(32-slbm_pkg::COUNT_W){1'b0}}, counts.prg_bank_count};
    end else begin
      prdata = {{(32-slbm_pkg::COUNT_W){1'b0}}, counts.chr_bank_count};
    end
  end

endmodule

FILE: src/slbm_state.sv
// Serial load shifter and the banking registers it updates.
module slbm_state (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    fire,
  input  slbm_pkg::item_t         item,
  output slbm_pkg::map_state_t    state,
  output slbm_pkg::map_state_t    state_next
);

  logic [slbm_pkg::SERIAL_BITS-1:0] serial_value;
  logic [slbm_pkg::SERIAL_BITS-1:0] serial_value_next;
  logic [2:0]                       serial_count;
  logic [2:0]                       serial_count_next;
  logic [slbm_pkg::SERIAL_BITS-1:0] shifted;
  logic [2:0]                       count_inc;
  logic                             reg_write;

  // Only CPU writes at 0x8000 and up reach the serial port
  assign reg_write = fire && (item.action == slbm_pkg::ACT_CPU_WR) && item.address[15];
  assign shifted   = serial_value |
                     (slbm_pkg::SERIAL_BITS'(item.write_data[0]) << serial_count);
  assign count_inc = serial_count + 3'd1;

  always_comb begin
    state_next        = state;
    serial_value_next = serial_value;
    serial_count_next = serial_count;
    if (reg_write) begin
      if (item.write_data[7]) begin
        serial_value_next       = '0;
        serial_count_next       = '0;
        state_next.program_mode = slbm_pkg::PRG_MODE_FIX_LAST;
      end else if (count_inc == 3'(slbm_pkg::SERIAL_BITS)) begin
        serial_value_next = '0;
        serial_count_next = '0;
        case (item.address[14:13])
          slbm_pkg::SEL_CONTROL: begin
            state_next.arrangement  = shifted[1:0];
            state_next.program_mode = shifted[3:2];
            state_next.chr_split    = shifted[4];
          end
          slbm_pkg::SEL_CHR0: state_next.chr_bank_first = shifted;
          slbm_pkg::SEL_CHR1: state_next.chr_bank_second = shifted;
          default: state_next.program_bank = shifted;
        endcase
      end else begin
        serial_value_next = shifted;
        serial_count_next = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      serial_value          <= '0;
      serial_count          <= '0;
      state.arrangement     <= 2'd0;
      state.program_mode    <= slbm_pkg::PRG_MODE_FIX_LAST;
      state.chr_split       <= 1'b0;
      state.chr_bank_first  <= '0;
      state.chr_bank_second <= slbm_pkg::BANK_W'(1);
      state.program_bank    <= '0;
    end else begin
      serial_value <= serial_value_next;
      serial_count <= serial_count_next;
      state        <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    serial_count < 3'(slbm_pkg::SERIAL_BITS))
    else $error("serial count past load point");
  a_reset_write: assert property (@(posedge clk) disable iff (rst)
    reg_write && item.write_data[7] |=>
      serial_count == 3'd0 && state.program_mode == slbm_pkg::PRG_MODE_FIX_LAST)
    else $error("reset write did not clear shifter");
  a_value_clear: assert property (@(posedge clk) disable iff (rst)
    serial_count == 3'd0 |-> serial_value == '0)
    else $error("stale shifter bits with empty count");
`endif

endmodule

FILE: src/slbm_xlate.sv
// Address translation of one bus access; banks from the current state, mirroring from the next.
module slbm_xlate (
  input  slbm_pkg::item_t         item,
  input  slbm_pkg::map_state_t    state,
  input  slbm_pkg::map_state_t    state_next,
  input  slbm_pkg::bank_counts_t  counts,
  output slbm_pkg::result_t       result
);

  logic                           prg_upper;
  logic [slbm_pkg::COUNT_W-1:0]   prg_bank;
  logic [slbm_pkg::COUNT_W-1:0]   fixed_last;
  logic                           chr_upper;
  logic [slbm_pkg::BANK_W-1:0]    chr_bank;

  assign prg_upper  = item.address[14];
  assign chr_upper  = item.address[12];
  assign fixed_last = (counts.prg_bank_count == '0) ? '0 : counts.prg_bank_count - 6'd1;

  always_comb begin
    case (state.program_mode)
      slbm_pkg::PRG_MODE_FIX_LAST:
        prg_bank = prg_upper ? fixed_last : {1'b0, state.program_bank};
      slbm_pkg::PRG_MODE_FIX_FIRST:
        prg_bank = prg_upper ? {1'b0, state.program_bank} : '0;
      default:
        prg_bank = {1'b0, state.program_bank[4:1], prg_upper};
    endcase
  end

  always_comb begin
    if (state.chr_split) begin
      chr_bank = chr_upper ? state.chr_bank_second : state.chr_bank_first;
    end else begin
      chr_bank = {state.chr_bank_first[4:1], chr_upper};
    end
  end

  always_comb begin
    result.target            = slbm_pkg::TGT_NONE;
    result.mapped_address    = '0;
    result.bank_out_of_range = 1'b0;
    result.mirroring         = state_next.arrangement;
    result.chr_split_mode    = state_next.chr_split;
    if (!item.action[1]) begin
      if (item.address[15]) begin
        if (item.action == slbm_pkg::ACT_CPU_WR) begin
          result.target         = slbm_pkg::TGT_REG;
          result.mapped_address = slbm_pkg::MAP_W'(item.address[14:13]);
        end else begin
          result.target            = slbm_pkg::TGT_PRG;
          result.mapped_address    = {prg_bank[4:0], item.address[13:0]};
          result.bank_out_of_range = prg_bank >= counts.prg_bank_count;
        end
      end else if (item.address[14:13] == 2'b11) begin
        result.target         = slbm_pkg::TGT_SRAM;
        result.mapped_address = slbm_pkg::MAP_W'(item.address[12:0]);
      end
    end else if (item.address[13]) begin
      result.target         = slbm_pkg::TGT_NT;
      result.mapped_address = slbm_pkg::MAP_W'(item.address[11:0]);
    end else begin
      result.target            = slbm_pkg::TGT_CHR;
      result.mapped_address    = slbm_pkg::MAP_W'({chr_bank, item.address[11:0]});
      result.bank_out_of_range = {1'b0, chr_bank} >= counts.chr_bank_count;
    end
  end

endmodule

FILE: src/serial_loaded_bank_mapper_core.sv
// Top level of the serial-loaded bank mapper: access pipeline and config port.
// Each access is held in the input register, then in the result register that drives rsp.
// Throughput: one access per cycle, limited only by rsp back-pressure.
// The bank state and serial shifter update in the cycle an access leaves the
// input register, so each access sees the state left by the one before it.
// Reset (rst, synchronous): pipeline empty, bank state and counts to defaults.
module serial_loaded_bank_mapper_core (
  input  logic        clk,
  input  logic        rst,
  slbm_req_if.sink    req,
  slbm_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  slbm_pkg::bank_counts_t counts;
  slbm_pkg::map_state_t   state;
  slbm_pkg::map_state_t   state_next;
  slbm_pkg::item_t        s1_item;
  slbm_pkg::result_t      result_next;
  slbm_pkg::result_t      result;
  logic                   s1_valid;
  logic                   out_valid;
  logic                   s1_adv;

  slbm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .counts  (counts)
  );

  // Input stage moves on whenever the result register is free or drains now.
  assign s1_adv    = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  // Payload register, no reset needed
  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_item.action     <= req.action;
      s1_item.address    <= req.address;
      s1_item.write_data <= req.write_data;
    end
  end

  // State commits only when the access actually moves into the result register
  slbm_state u_state (
    .clk        (clk),
    .rst        (rst),
    .fire       (s1_adv),
    .item       (s1_item),
    .state      (state),
    .state_next (state_next)
  );

  slbm_xlate u_xlate (
    .item       (s1_item),
    .state      (state),
    .state_next (state_next),
    .counts     (counts),
    .result     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result <= result_next;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.target            = result.target;
  assign rsp.mapped_address    = result.mapped_address;
  assign rsp.bank_out_of_range = result.bank_out_of_range;
  assign rsp.mirroring         = result.mirroring;
  assign rsp.chr_split_mode    = result.chr_split_mode;

`ifndef SYNTHESIS
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_item))
    else $error("stalled input stage lost its access");
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && rsp.target == slbm_pkg::TGT_NONE |->
      rsp.mapped_address == '0 && !rsp.bank_out_of_range)
    else $error("ignored access carries an address");
  a_flag_banked: assert property (@(posedge clk) disable iff (rst)
    out_valid && rsp.bank_out_of_range |->
      rsp.target == slbm_pkg::TGT_PRG || rsp.target == slbm_pkg::TGT_CHR)
    else $error("range flag on unbanked target");
  a_state_idle: assert property (@(posedge clk) disable iff (rst)
    !s1_adv |=> $stable(state))
    else $error("bank state changed without an access");
`endif

endmodule

FILE: verif/serial_loaded_bank_mapper_core_test.sv
// Self-checking testbench for the serial-loaded bank mapper core.
module serial_loaded_bank_mapper_core_test;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  slbm_req_if req_ch ();
  slbm_rsp_if rsp_ch ();

  serial_loaded_bank_mapper_core DUT (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch.sink),
    .rsp     (rsp_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // ---------------------------------------------------------------------------
  // Mirror of the mapper state, advanced once per accepted access
  // ---------------------------------------------------------------------------
  slbm_pkg::map_state_t   bank_regs;
  slbm_pkg::bank_counts_t counts;
  logic [4:0]             shift_val;
  logic [2:0]             shift_cnt;

  slbm_pkg::item_t   access_q[$];     // accesses waiting to be driven
  slbm_pkg::result_t expected_q[$];   // translations predicted, not yet seen on rsp
  slbm_pkg::item_t   in_flight;       // access currently presented on req
  slbm_pkg::result_t predicted;
  slbm_pkg::result_t seen;
  slbm_pkg::result_t want;

  int  errors;
  int  accesses_sent;
  int  results_checked;
  int  reg_loads;
  int  settings_run;
  int  target_hits[6];
  int  gap_left;
  int  stall_left;
  bit  feed_calm;
  bit  sink_calm;
  logic next_ready;

  // Translate one bus access; serial writes update the mirrored state in order.
  task automatic map_access(input slbm_pkg::item_t acc, output slbm_pkg::result_t res);
    logic [15:0] a;
    logic [5:0]  bank;
    logic        upper;
    logic [4:0]  sv;
    a = acc.address;
    res = '0;
    bank = '0;
    if (acc.action == slbm_pkg::ACT_CPU_RD || acc.action == slbm_pkg::ACT_CPU_WR) begin
      if (a < 16'h6000) begin
        // below save RAM: no target, state untouched
      end else if (a < 16'h8000) begin
        res.target = slbm_pkg::TGT_SRAM;
        res.mapped_address = slbm_pkg::MAP_W'(a - 16'h6000);
      end else if (acc.action == slbm_pkg::ACT_CPU_WR) begin
        res.target = slbm_pkg::TGT_REG;
        res.mapped_address = slbm_pkg::MAP_W'(a[14:13]);
        if (acc.write_data[7]) begin
          // bit 7 aborts the shift and forces last-bank-fixed mode
          shift_val = '0;
          shift_cnt = '0;
          bank_regs.program_mode = slbm_pkg::PRG_MODE_FIX_LAST;
        end else begin
          sv = shift_val | (5'(acc.write_data[0]) << shift_cnt);
          shift_val = sv;
          shift_cnt = shift_cnt + 3'd1;
          if (shift_cnt >= slbm_pkg::SERIAL_BITS) begin
            case (a[14:13])
              slbm_pkg::SEL_CONTROL: begin
                bank_regs.arrangement = sv[1:0];
                bank_regs.program_mode = sv[3:2];
                bank_regs.chr_split = sv[4];
              end
              slbm_pkg::SEL_CHR0: bank_regs.chr_bank_first = sv;
              slbm_pkg::SEL_CHR1: bank_regs.chr_bank_second = sv;
              default: bank_regs.program_bank = sv;
            endcase
            shift_val = '0;
            shift_cnt = '0;
            reg_loads++;
          end
        end
      end else begin
        upper = a[14];
        case (bank_regs.program_mode)
          slbm_pkg::PRG_MODE_FIX_LAST:
            if (!upper) bank = {1'b0, bank_regs.program_bank};
            else if (counts.prg_bank_count == 0) bank = '0;
            else bank = counts.prg_bank_count - 6'd1;
          slbm_pkg::PRG_MODE_FIX_FIRST:
            bank = upper ? {1'b0, bank_regs.program_bank} : 6'd0;
          default:  // 32K modes: even/odd pair
            bank = {1'b0, bank_regs.program_bank[4:1], upper};
        endcase
        res.target = slbm_pkg::TGT_PRG;
        res.mapped_address = {bank[4:0], a[13:0]};  // wraps above bank 31
        res.bank_out_of_range = (bank >= counts.prg_bank_count);
      end
    end else begin
      // PPU: only 14 address bits; writes map like reads
      if (a[13]) begin
        res.target = slbm_pkg::TGT_NT;
        res.mapped_address = slbm_pkg::MAP_W'(a[11:0]);
      end else begin
        upper = a[12];
        if (bank_regs.chr_split)
          bank = {1'b0, upper ? bank_regs.chr_bank_second : bank_regs.chr_bank_first};
        else
          bank = {1'b0, bank_regs.chr_bank_first[4:1], upper};
        res.target = slbm_pkg::TGT_CHR;
        res.mapped_address = slbm_pkg::MAP_W'({bank[4:0], a[11:0]});
        res.bank_out_of_range = (bank >= counts.chr_bank_count);
      end
    end
    res.mirroring = bank_regs.arrangement;
    res.chr_split_mode = bank_regs.chr_split;
  endtask

  function automatic slbm_pkg::item_t mk(logic [1:0] act, logic [15:0] addr,
                                         logic [7:0] data);
    slbm_pkg::item_t it;
    it.action = act;
    it.address = addr;
    it.write_data = data;
    return it;
  endfunction

  // Mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Five serial bits, LSB first; register picked by the fifth write's address.
  // Now and then a PPU read lands between bits.
  task automatic push_serial_load(input logic [1:0] sel, input logic [4:0] val);
    logic [15:0] a;
    for (int i = 0; i < slbm_pkg::SERIAL_BITS; i++) begin
      a = 16'h8000 | 16'($urandom);
      if (i == slbm_pkg::SERIAL_BITS - 1) a[14:13] = sel;
      access_q.push_back(mk(slbm_pkg::ACT_CPU_WR, a, {1'b0, 6'($urandom), val[i]}));
      if ($urandom_range(0, 4) == 0)
        access_q.push_back(mk(slbm_pkg::ACT_PPU_RD, 16'($urandom) & 16'hDFFF,
                              8'($urandom)));
    end
  endtask

  task automatic push_random_mix(input int n);
    int made;
    int pick;
    int k;
    logic [15:0] a;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        push_serial_load(2'($urandom), 5'($urandom));
        made += slbm_pkg::SERIAL_BITS;
      end else if (pick < 36) begin
        // broken sequence: a few bits, then an abort
        k = $urandom_range(1, 4);
        repeat (k)
          access_q.push_back(mk(slbm_pkg::ACT_CPU_WR, 16'h8000 | 16'($urandom),
                                8'($urandom) & 8'h7F));
        access_q.push_back(mk(slbm_pkg::ACT_CPU_WR, 16'h8000 | 16'($urandom),
                              8'($urandom) | 8'h80));
        made += k + 1;
      end else if (pick < 60) begin
        access_q.push_back(mk(slbm_pkg::ACT_CPU_RD, 16'h8000 | 16'($urandom),
                              8'($urandom)));
        made++;
      end else if (pick < 85) begin
        a = 16'($urandom);
        if ($urandom_range(0, 9) < 7) a[13] = 1'b0;  // favor pattern space
        access_q.push_back(mk($urandom_range(0, 1) ? slbm_pkg::ACT_PPU_WR :
                              slbm_pkg::ACT_PPU_RD, a, 8'($urandom)));
        made++;
      end else if (pick < 95) begin
        access_q.push_back(mk($urandom_range(0, 1) ? slbm_pkg::ACT_CPU_WR :
                              slbm_pkg::ACT_CPU_RD,
                              16'h6000 | (16'($urandom) & 16'h1FFF), 8'($urandom)));
        made++;
      end else if (pick < 98) begin
        // ignored region, kept rare and not counted
        access_q.push_back(mk($urandom_range(0, 1) ? slbm_pkg::ACT_CPU_WR :
                              slbm_pkg::ACT_CPU_RD,
                              16'($urandom_range(0, 16'h5FFF)), 8'($urandom)));
      end else begin
        access_q.push_back(mk(2'($urandom), 16'($urandom), 8'($urandom)));
        made++;
      end
    end
  endtask

  // APB write: setup cycle, access cycle; register takes the value at the
  // edge that ends the access cycle. Upper data bits are don't-care noise.
  task automatic write_count(input logic idx, input logic [slbm_pkg::COUNT_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {26'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == slbm_pkg::REG_PRG_COUNT) counts.prg_bank_count = val;
    else counts.chr_bank_count = val;
  endtask

  // Waits until every queued access is sent and every predicted translation has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (access_q.size() != 0 || req_ch.valid || expected_q.size() != 0);
  endtask

  task automatic check_field(input string what, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, act_v);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous cap: worst case is every access hitting a long gap and a long stall
  initial begin
    #5000000;
    $display("serial_loaded_bank_mapper_core_test: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: one transfer per accepted access, payload held while stalled
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        map_access(in_flight, predicted);
        expected_q.push_back(predicted);
        accesses_sent++;
        gap_left = pick_gap(feed_calm);
        if ($urandom_range(0, 63) == 0) feed_calm = !feed_calm;
      end
      if (req_ch.valid && !req_ch.ready) begin
        // stalled: keep the current transfer on the bus
      end else if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (access_q.size() != 0) begin
        in_flight = access_q.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.action <= in_flight.action;
        req_ch.address <= in_flight.address;
        req_ch.write_data <= in_flight.write_data;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result transfer against the oldest prediction,
  // and throttle ready independently of valid
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        seen.target = rsp_ch.target;
        seen.mapped_address = rsp_ch.mapped_address;
        seen.bank_out_of_range = rsp_ch.bank_out_of_range;
        seen.mirroring = rsp_ch.mirroring;
        seen.chr_split_mode = rsp_ch.chr_split_mode;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 40)
            $display("%0t: unexpected result, expected none, got %h", $time, seen);
        end else begin
          want = expected_q.pop_front();
          check_field("target", 32'(want.target), 32'(seen.target));
          check_field("mapped_address", 32'(want.mapped_address),
                      32'(seen.mapped_address));
          check_field("bank_out_of_range", 32'(want.bank_out_of_range),
                      32'(seen.bank_out_of_range));
          check_field("mirroring", 32'(want.mirroring), 32'(seen.mirroring));
          check_field("chr_split_mode", 32'(want.chr_split_mode),
                      32'(seen.chr_split_mode));
          if (want.target <= slbm_pkg::TGT_REG) target_hits[want.target]++;
          results_checked++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else if (!sink_calm && $urandom_range(0, 9) == 0) begin
        stall_left = pick_gap(1'b0);
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      if ($urandom_range(0, 127) == 0) sink_calm = !sink_calm;
      rsp_ch.ready <= next_ready;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: reset, directed corners, then random phases over bank counts
  // ---------------------------------------------------------------------------
  logic [slbm_pkg::COUNT_W-1:0] prg_plan[5];
  logic [slbm_pkg::COUNT_W-1:0] chr_plan[5];

  initial begin
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.action = slbm_pkg::ACT_CPU_RD;
    req_ch.address = '0;
    req_ch.write_data = '0;
    rsp_ch.ready = 1'b0;
    errors = 0;
    accesses_sent = 0;
    results_checked = 0;
    reg_loads = 0;
    gap_left = 0;
    stall_left = 0;
    feed_calm = 1'b0;
    sink_calm = 1'b0;
    foreach (target_hits[i]) target_hits[i] = 0;

    // mirror of reset state
    bank_regs = '0;
    bank_regs.program_mode = slbm_pkg::PRG_MODE_FIX_LAST;
    bank_regs.chr_bank_second = 5'd1;
    counts.prg_bank_count = slbm_pkg::PRG_COUNT_RST;
    counts.chr_bank_count = slbm_pkg::CHR_COUNT_RST;
    shift_val = '0;
    shift_cnt = '0;

    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed corners at reset counts
    access_q.push_back(mk(slbm_pkg::ACT_CPU_RD, 16'h0000, 8'h00));  // ignored low region
    access_q.push_back(mk(slbm_pkg::ACT_CPU_WR, 16'h5FFF, 8'hFF));  // ignored, no abort
    access_q.push_back(mk(slbm_pkg::ACT_CPU_RD, 16'h6000, 8'h00));  // save RAM base
    access_q.push_back(mk(slbm_pkg::ACT_CPU_WR, 16'h7FFF, 8'hFF));  // save RAM top
    access_q.push_back(mk(slbm_pkg::ACT_CPU_RD, 16'h8000, 8'h00));  // switchable low bank
    access_q.push_back(mk(slbm_pkg::ACT_CPU_RD, 16'hFFFF, 8'hFF));  // fixed last bank
    access_q.push_back(mk(slbm_pkg::ACT_PPU_RD, 16'h0000, 8'h00));  // CHR low half
    access_q.push_back(mk(slbm_pkg::ACT_PPU_WR, 16'h1FFF, 8'hFF));  // CHR high half
    access_q.push_back(mk(slbm_pkg::ACT_PPU_RD, 16'h2000, 8'h00));  // nametable base
    access_q.push_back(mk(slbm_pkg::ACT_PPU_RD, 16'hFFFF, 8'h00));  // masked to 14 bits
    access_q.push_back(mk(slbm_pkg::ACT_CPU_WR, 16'h8000, 8'h01));  // partial shift...
    access_q.push_back(mk(slbm_pkg::ACT_CPU_WR, 16'h8000, 8'hFF));  // ...aborted
    push_serial_load(slbm_pkg::SEL_CONTROL, 5'b10010);              // 32K mode, split CHR
    push_serial_load(slbm_pkg::SEL_PRG, 5'h1F);                     // top bank, out of range
    access_q.push_back(mk(slbm_pkg::ACT_CPU_RD, 16'h8000, 8'h00));  // even half of pair
    access_q.push_back(mk(slbm_pkg::ACT_CPU_RD, 16'hC000, 8'h00));  // odd half of pair
    access_q.push_back(mk(slbm_pkg::ACT_PPU_RD, 16'h1000, 8'h00));  // split: second bank
    push_random_mix(85);
    wait_drained();
    settings_run = 1;

    // Extremes first (one bank, full size, zero, field max), then random
    prg_plan = '{6'd1, 6'd32, 6'd0, 6'd63, 6'($urandom_range(1, 32))};
    chr_plan = '{6'd32, 6'd1, 6'd63, 6'd0, 6'($urandom_range(1, 32))};
    for (int p = 0; p < 5; p++) begin
      write_count(slbm_pkg::REG_PRG_COUNT, prg_plan[p]);
      write_count(slbm_pkg::REG_CHR_COUNT, chr_plan[p]);
      @(negedge clk);
      push_random_mix(110);
      wait_drained();
      settings_run++;
    end

    // late or extra results still get caught by the monitor here
    repeat (20) @(posedge clk);

    $display("covered %0d accesses (%0d checked) over %0d bank-count settings, %0d loads",
             accesses_sent, results_checked, settings_run, reg_loads);
    $display("targets none/prg/sram/chr/nt/reg: %0d/%0d/%0d/%0d/%0d/%0d",
             target_hits[slbm_pkg::TGT_NONE], target_hits[slbm_pkg::TGT_PRG],
             target_hits[slbm_pkg::TGT_SRAM], target_hits[slbm_pkg::TGT_CHR],
             target_hits[slbm_pkg::TGT_NT], target_hits[slbm_pkg::TGT_REG]);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("serial_loaded_bank_mapper_core_test: done, clean");
    end else begin
      $display("serial_loaded_bank_mapper_core_test: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
src/slbm_pkg.sv
src/slbm_if.sv
src/slbm_cfg.sv
src/slbm_state.sv
src/slbm_xlate.sv
src/serial_loaded_bank_mapper_core.sv
verif/serial_loaded_bank_mapper_core_test.sv
